### rtl/mtlru_pkg.sv
`timescale 1ns / 1ps
// package for the partitioned lru buffer pool
// holds sizes, register indexes and the sequencer state type; no dependencies
package mtlru_pkg;
	localparam int TENANTS_DEF = 4;
	localparam int POOL_SLOTS_DEF = 64;
	localparam int SLOT_W = 7;
	localparam int TN_W = 3;
	localparam int PAGE_W = 32;
	localparam int CFG_W = 64;
	localparam int CIDX_W = 2;

	localparam logic [CIDX_W-1:0] REG_TENANT_COUNT = 2'd0;
	localparam logic [CIDX_W-1:0] REG_INIT_CAPS = 2'd1;
	localparam logic [CIDX_W-1:0] REG_MAX_CAPS = 2'd2;
	localparam logic [CIDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_DECIDE,
		ST_AGE,
		ST_DONE
	} state_t;
endpackage

### rtl/multi_tenant_lru_buffer_pool.sv
`timescale 1ns / 1ps
// partitioned lru buffer pool top level: slot table memory and scan sequencer
// depends on mtlru_pkg
//
// Usage: a request (tenant, page) enters on in_valid/in_stall; one result
// (slot, hit, error) leaves on out_valid/out_stall per request.
// The slot table (owner, page, rank) sits in a synchronous memory with one
// read and one write port and registered reads. A request runs a find pass
// over all POOL_SLOTS entries (match and oldest entry in one sweep), a decide
// state, then, unless there is no hit, no free slot and nothing to evict, an
// aging pass that reads each entry and writes back the target and the
// tenant's entries ranked below it. Each pass walks the memory port one entry
// a cycle. A bad tenant goes straight to the done state. One request is in
// flight at a time; in_stall is high while busy or while a result waits, so
// a new request is taken only after the last result has left. The result
// sits in an output register; while out_stall is high it holds and no new
// request is taken. Reset clears valid flags through per-entry valid bits (no
// clearing pass), counters, quotas and spare count; the user must make
// configuration writes only while idle; the block itself does not enforce it.
module multi_tenant_lru_buffer_pool #(
	parameter int TENANTS = mtlru_pkg::TENANTS_DEF,
	parameter int POOL_SLOTS = mtlru_pkg::POOL_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [mtlru_pkg::CIDX_W-1:0] cfg_index,
	input  logic [mtlru_pkg::CFG_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [mtlru_pkg::TN_W-1:0] tenant,
	input  logic [mtlru_pkg::PAGE_W-1:0] page,
	output logic out_valid,
	input  logic out_stall,
	output logic [mtlru_pkg::SLOT_W-1:0] slot,
	output logic hit,
	output logic error
);
	localparam int AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int CW = $clog2(POOL_SLOTS + 1);
	localparam int RW = AW;
	localparam int SW = mtlru_pkg::SLOT_W;

	typedef struct packed {
		logic [1:0] owner;
		logic [mtlru_pkg::PAGE_W-1:0] pg;
		logic [RW-1:0] rank;
	} entry_t;

	entry_t mem_q [POOL_SLOTS];
	logic [POOL_SLOTS-1:0] valid_q;
	entry_t rd_s1;
	logic rv_s1;
	logic [AW-1:0] raddr;
	logic mem_we;
	logic [AW-1:0] waddr;
	entry_t wdata;

	logic [2:0] tcount_q;
	logic [mtlru_pkg::CFG_W-1:0] maxcap_q;
	logic [CW-1:0] quota_q [TENANTS];
	logic [CW-1:0] used_q [TENANTS];
	logic [SW-1:0] spare_q;
	logic [CW-1:0] next_q;

	mtlru_pkg::state_t state_q, state_d;
	logic [1:0] t_q;
	logic [mtlru_pkg::PAGE_W-1:0] page_q;
	logic [CW:0] cnt_q;
	logic [AW-1:0] addr_s1;
	logic busy_rd_s1;
	logic found_q;
	logic [AW-1:0] fslot_q;
	logic [RW-1:0] frank_q;
	logic old_q;
	logic [AW-1:0] oslot_q;
	logic [RW-1:0] orank_q;
	// aging pass controls
	logic [AW-1:0] tgt_q;
	logic [CW:0] limit_q;
	logic [SW-1:0] slot_q;
	logic hit_q, err_q, ovalid_q;

	logic in_acc, out_acc, tn_ok, scan_end, age_end;
	logic [2:0] active;
	logic [15:0] maxcap_t;
	logic fresh_ok, take_quota, take_grow;

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (state_q != mtlru_pkg::ST_IDLE) || ovalid_q;
	assign out_valid = ovalid_q;
	assign slot = slot_q;
	assign hit = hit_q;
	assign error = err_q;

	assign active = (tcount_q < 3'(TENANTS)) ? tcount_q : 3'(TENANTS);
	assign tn_ok = (tenant != '0) && (tenant <= active);
	assign scan_end = busy_rd_s1 && (cnt_q == (CW+1)'(POOL_SLOTS));
	assign age_end = scan_end;
	assign maxcap_t = maxcap_q[16*t_q +: 16];
	assign fresh_ok = next_q < CW'(POOL_SLOTS);
	assign take_quota = fresh_ok && (used_q[t_q] < quota_q[t_q]);
	assign take_grow = fresh_ok && ({{(16-CW){1'b0}}, used_q[t_q]} < maxcap_t)
		&& (spare_q != '0);

	// memory: one read port, one write port
	always_ff @(posedge clk) begin
		rd_s1 <= mem_q[raddr];
		if (mem_we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= valid_q[raddr];
		end
	end

	assign raddr = cnt_q[AW-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mtlru_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = tn_ok ? mtlru_pkg::ST_FIND : mtlru_pkg::ST_DONE;
				end
			end
			mtlru_pkg::ST_FIND: begin
				if (scan_end) begin
					state_d = mtlru_pkg::ST_DECIDE;
				end
			end
			mtlru_pkg::ST_DECIDE: begin
				if (!found_q && !take_quota && !take_grow
					&& (used_q[t_q] == '0 || !old_q)) begin
					state_d = mtlru_pkg::ST_DONE;
				end else begin
					state_d = mtlru_pkg::ST_AGE;
				end
			end
			mtlru_pkg::ST_AGE: begin
				if (age_end) begin
					state_d = mtlru_pkg::ST_DONE;
				end
			end
			mtlru_pkg::ST_DONE: state_d = mtlru_pkg::ST_IDLE;
			default: state_d = mtlru_pkg::ST_IDLE;
		endcase
	end

	// aging write: read entry returned in rd_s1 for address addr_s1
	always_comb begin
		mem_we = 1'b0;
		waddr = addr_s1;
		wdata = rd_s1;
		if (state_q == mtlru_pkg::ST_AGE && busy_rd_s1) begin
			if (addr_s1 == tgt_q) begin
				mem_we = 1'b1;
				wdata.owner = t_q;
				wdata.pg = page_q;
				wdata.rank = '0;
			end else if (rv_s1 && rd_s1.owner == t_q
				&& {1'b0, CW'(rd_s1.rank)} < limit_q) begin
				mem_we = 1'b1;
				wdata.rank = rd_s1.rank + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtlru_pkg::ST_IDLE;
			tcount_q <= 3'd1;
			maxcap_q <= '0;
			spare_q <= '0;
			next_q <= '0;
			valid_q <= '0;
			ovalid_q <= 1'b0;
			cnt_q <= '0;
			busy_rd_s1 <= 1'b0;
			for (int i = 0; i < TENANTS; i++) begin
				quota_q[i] <= '0;
				used_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_acc) begin
				ovalid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					mtlru_pkg::REG_TENANT_COUNT: tcount_q <= cfg_data[2:0];
					mtlru_pkg::REG_INIT_CAPS: begin
						for (int i = 0; i < TENANTS; i++) begin
							quota_q[i] <= (cfg_data[16*i +: 16] > 16'(POOL_SLOTS))
								? CW'(POOL_SLOTS) : CW'(cfg_data[16*i +: 16]);
						end
					end
					mtlru_pkg::REG_MAX_CAPS: maxcap_q <= cfg_data;
					mtlru_pkg::REG_SPARE: spare_q <= cfg_data[SW-1:0];
					default: ;
				endcase
			end
			// sweep address counter for both passes
			busy_rd_s1 <= 1'b0;
			if ((state_q == mtlru_pkg::ST_FIND || state_q == mtlru_pkg::ST_AGE)
				&& !scan_end) begin
				if (cnt_q < (CW+1)'(POOL_SLOTS)) begin
					cnt_q <= cnt_q + 1'b1;
				end
				busy_rd_s1 <= 1'b1;
			end
			if (in_acc || state_q == mtlru_pkg::ST_DECIDE) begin
				cnt_q <= '0;
			end
			if (state_q == mtlru_pkg::ST_DECIDE && !found_q) begin
				if (take_quota || take_grow) begin
					next_q <= next_q + 1'b1;
					valid_q[next_q[AW-1:0]] <= 1'b1;
					used_q[t_q] <= used_q[t_q] + 1'b1;
					if (!take_quota) begin
						spare_q <= spare_q - 1'b1;
						if (quota_q[t_q] < CW'(POOL_SLOTS)) begin
							quota_q[t_q] <= quota_q[t_q] + 1'b1;
						end
					end
				end
			end
			if (state_q == mtlru_pkg::ST_DONE) begin
				ovalid_q <= 1'b1;
			end
		end
	end

	// request payload, scan results and result fields
	always_ff @(posedge clk) begin
		addr_s1 <= raddr;
		if (in_acc) begin
			t_q <= 2'(tenant - 1'b1);
			page_q <= page;
			found_q <= 1'b0;
			old_q <= 1'b0;
			err_q <= 1'b1;
			hit_q <= 1'b0;
			slot_q <= '0;
		end
		if (state_q == mtlru_pkg::ST_FIND && busy_rd_s1 && rv_s1
			&& rd_s1.owner == t_q) begin
			if (!found_q && rd_s1.pg == page_q) begin
				found_q <= 1'b1;
				fslot_q <= addr_s1;
				frank_q <= rd_s1.rank;
			end
			if (!old_q || rd_s1.rank >= orank_q) begin
				old_q <= 1'b1;
				oslot_q <= addr_s1;
				orank_q <= rd_s1.rank;
			end
		end
		if (state_q == mtlru_pkg::ST_DECIDE && state_d == mtlru_pkg::ST_AGE) begin
			err_q <= 1'b0;
			if (found_q) begin
				tgt_q <= fslot_q;
				limit_q <= (CW+1)'(frank_q);
				hit_q <= 1'b1;
				slot_q <= SW'(fslot_q) + 1'b1;
			end else if (take_quota || take_grow) begin
				tgt_q <= next_q[AW-1:0];
				limit_q <= '1;
				slot_q <= SW'(next_q) + 1'b1;
			end else begin
				tgt_q <= oslot_q;
				limit_q <= (CW+1)'(orank_q);
				slot_q <= SW'(oslot_q) + 1'b1;
			end
		end
	end
endmodule
